/* design/bnd_pkg.sv */
// Shared types, register indexes and constants for the Bayer 3x3 demosaic.
// No dependencies; bnd_ctrl, bnd_dp, the top level and the checker import this package.
package bnd_pkg;

    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W = 20;       // 9 * 65535 fits in 20 bits
    localparam int CNT_W = 4;        // up to 9 cells per colour
    localparam int ACC_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BIAS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SWAP_BYTES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BAYER_PATTERN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE = 3'd5;

    localparam logic [1:0] CLR_RED = 2'd0;
    localparam logic [1:0] CLR_GREEN = 2'd1;
    localparam logic [1:0] CLR_BLUE = 2'd2;
    localparam logic [1:0] CLR_GREEN_ALT = 2'd3;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] raw_sample;
    } bnd_in_t;

    typedef struct packed {
        logic [15:0] gray;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        frame_last;
    } bnd_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       sum;
        logic       div_step;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       load_out;
    } bnd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic emit;
        logic mono_result;
        logic out_free;
    } bnd_sts_t;

    // Fixed-point luma weights, scaled by 2^16
    function automatic logic [15:0] luma_coef(input logic [1:0] sel);
        logic [15:0] c;
        unique case (sel)
            CLR_RED:   c = 16'd13933;
            CLR_GREEN: c = 16'd46871;
            CLR_BLUE:  c = 16'd4732;
            default:   c = 16'd0;
        endcase
        return c;
    endfunction

endpackage

/* design/bnd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bnd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/bnd_ctrl.sv */
// Sequencer for the demosaic: accept, step, sum, divide, luma, deliver.
// Depends on bnd_pkg.
module bnd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bnd_pkg::bnd_sts_t sts,
    output bnd_pkg::bnd_cmd_t cmd
);
    import bnd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(2);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (sts.mono_result)
                begin
                    state_next = ST_OUT;
                end
                else if (sts.emit)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                step_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    step_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel = step_reg[1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

endmodule

/* design/bnd_dp.sv */
// Datapath: config registers, raster counters, line store, 3x3 window,
// colour sums, serial dividers, luma accumulator and output register.
// Depends on bnd_pkg and bnd_ram.
module bnd_dp #(
    parameter int MAX_WIDTH = bnd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bnd_pkg::bnd_in_t                   in_data,
    input  logic                               cfg_we,
    input  logic [bnd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bnd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  bnd_pkg::bnd_cmd_t                  cmd,
    output bnd_pkg::bnd_sts_t                  sts,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bnd_pkg::bnd_out_t                  out_data
);
    import bnd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration
    logic [12:0] fw_reg;
    logic [15:0] fh_reg, bias_reg;
    logic        swap_reg, mono_reg;
    logic [7:0]  pat_reg;
    logic        restart;

    assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                                cfg_index == REG_FRAME_HEIGHT ||
                                cfg_index == REG_MONO_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 13'd4096;
            fh_reg <= 16'd2;
            bias_reg <= 16'd32768;
            swap_reg <= 1'b1;
            pat_reg <= 8'd148;
            mono_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   fw_reg <= cfg_data[12:0];
                REG_FRAME_HEIGHT:  fh_reg <= cfg_data;
                REG_SAMPLE_BIAS:   bias_reg <= cfg_data;
                REG_SWAP_BYTES:    swap_reg <= cfg_data[0];
                REG_BAYER_PATTERN: pat_reg <= cfg_data[7:0];
                REG_MONO_MODE:     mono_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Effective geometry
    logic [CW-1:0] w;
    logic [15:0]   h;

    always_comb
    begin
        priority if (fw_reg < 13'd2)
        begin
            w = CW'(2);
        end
        else if (int'(fw_reg) > MAX_WIDTH)
        begin
            w = CW'(MAX_WIDTH);
        end
        else
        begin
            w = CW'(fw_reg);
        end
        h = (fh_reg < 16'd2) ? 16'd2 : fh_reg;
    end

    // Captured item
    logic        drain_reg;
    logic [15:0] v_reg;
    logic [15:0] swapped;

    assign swapped = swap_reg ? {in_data.raw_sample[7:0], in_data.raw_sample[15:8]}
                              : in_data.raw_sample;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            drain_reg <= in_data.func;
            v_reg <= swapped + bias_reg;
        end
    end

    // Raster counters
    logic [CW-1:0] ic_reg, ic_next;
    logic [15:0]   ir_reg, ir_next;
    logic [CW:0]   ic_inc;
    logic [16:0]   ir_inc;
    logic          row_end, in_frame, active, corner, emit, mono_res;
    logic [15:0]   er;
    logic [CW-1:0] ec;

    assign ic_inc = {1'b0, ic_reg} + 1'b1;
    assign ir_inc = {1'b0, ir_reg} + 1'b1;
    assign row_end = (ic_inc >= {1'b0, w});
    assign in_frame = (ir_reg < h);
    assign mono_res = mono_reg && !drain_reg;
    assign active = !mono_reg && (in_frame ? !drain_reg : drain_reg);
    assign corner = active && !in_frame && (ic_reg >= w);
    assign emit = corner ||
                  (active && ((ic_reg == '0 && ir_reg >= 16'd2) ||
                              (ic_reg != '0 && ir_reg != '0)));

    // Pixel whose neighborhood sits centered in the window after the shift
    always_comb
    begin
        priority if (corner)
        begin
            er = h - 16'd1;
            ec = w - 1'b1;
        end
        else if (ic_reg == '0)
        begin
            er = ir_reg - 16'd2;
            ec = w - 1'b1;
        end
        else
        begin
            er = ir_reg - 16'd1;
            ec = ic_reg - 1'b1;
        end
    end

    always_comb
    begin
        ic_next = ic_reg;
        ir_next = ir_reg;
        if (cmd.exec)
        begin
            priority if (mono_res)
            begin
                if (row_end)
                begin
                    ic_next = '0;
                    ir_next = (ir_inc >= {1'b0, h}) ? 16'd0 : ir_inc[15:0];
                end
                else
                begin
                    ic_next = ic_inc[CW-1:0];
                end
            end
            else if (corner)
            begin
                ic_next = '0;
                ir_next = '0;
            end
            else if (active)
            begin
                priority if (!in_frame)
                begin
                    ic_next = ic_inc[CW-1:0];
                end
                else if (row_end)
                begin
                    ic_next = '0;
                    ir_next = ir_inc[15:0];
                end
                else
                begin
                    ic_next = ic_inc[CW-1:0];
                end
            end
            else
            begin
                ic_next = ic_reg;
            end
        end
        if (restart)
        begin
            ic_next = '0;
            ir_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg <= '0;
            ir_reg <= '0;
        end
        else
        begin
            ic_reg <= ic_next;
            ir_reg <= ir_next;
        end
    end

    // Line store: one bank per row parity
    logic [15:0]   wval;
    logic [15:0]   rd0, rd1;
    logic [AW-1:0] laddr;
    logic          we0, we1;

    assign wval = drain_reg ? 16'd0 : v_reg;
    assign laddr = ic_reg[AW-1:0];
    assign we0 = cmd.exec && active && !corner && !ir_reg[0];
    assign we1 = cmd.exec && active && !corner && ir_reg[0];

    bnd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_bank0 (
        .clk(clk), .we(we0), .waddr(laddr), .wdata(wval), .raddr(laddr), .rdata(rd0)
    );

    bnd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_bank1 (
        .clk(clk), .we(we1), .waddr(laddr), .wdata(wval), .raddr(laddr), .rdata(rd1)
    );

    // 3x3 window, column 2 newest
    logic [15:0] win_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (cmd.exec && active)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= ir_reg[0] ? rd1 : rd0;
            win_reg[1][2] <= ir_reg[0] ? rd0 : rd1;
            win_reg[2][2] <= wval;
        end
    end

    // Emitted pixel position
    logic [15:0]   r_reg;
    logic [CW-1:0] c_reg;
    logic          last_reg, mono_item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            r_reg <= er;
            c_reg <= ec;
            mono_item_reg <= mono_res;
            last_reg <= mono_res ? ((ir_reg >= h - 16'd1) && (ic_reg >= w - 1'b1))
                                 : ((er == h - 16'd1) && (ec == w - 1'b1));
        end
    end

    // Masked colour sums over the window
    logic [SUM_W-1:0] sum_c [3];
    logic [CNT_W-1:0] cnt_c [3];

    always_comb
    begin
        logic       rok, cok, rp, cp;
        logic [1:0] code;
        logic [1:0] ci;
        for (int k = 0; k < 3; k++)
        begin
            sum_c[k] = '0;
            cnt_c[k] = '0;
        end
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                rok = (dr == 0) ? (r_reg != 16'd0) :
                      (dr == 2) ? (r_reg != h - 16'd1) : 1'b1;
                cok = (dc == 0) ? (c_reg != '0) :
                      (dc == 2) ? (c_reg != w - 1'b1) : 1'b1;
                rp = r_reg[0] ^ (dr != 1);
                cp = c_reg[0] ^ (dc != 1);
                code = pat_reg[{rp, cp, 1'b0} +: 2];
                ci = (code == CLR_RED) ? CLR_RED :
                     (code == CLR_BLUE) ? CLR_BLUE : CLR_GREEN;
                if (rok && cok)
                begin
                    sum_c[ci] = sum_c[ci] + SUM_W'(win_reg[dr][dc]);
                    cnt_c[ci] = cnt_c[ci] + 1'b1;
                end
            end
        end
    end

    // Restoring dividers, one quotient bit per cycle in each lane
    logic [SUM_W-1:0] dvd_reg [3];
    logic [CNT_W-1:0] rem_reg [3];
    logic [CNT_W-1:0] div_reg [3];

    always_ff @(posedge clk)
    begin
        logic [CNT_W:0] trial;
        for (int k = 0; k < 3; k++)
        begin
            trial = {rem_reg[k], dvd_reg[k][SUM_W-1]};
            if (cmd.sum)
            begin
                dvd_reg[k] <= sum_c[k];
                rem_reg[k] <= '0;
                div_reg[k] <= cnt_c[k];
            end
            else if (cmd.div_step)
            begin
                if (trial >= {1'b0, div_reg[k]})
                begin
                    rem_reg[k] <= CNT_W'(trial - {1'b0, div_reg[k]});
                    dvd_reg[k] <= {dvd_reg[k][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= trial[CNT_W-1:0];
                    dvd_reg[k] <= {dvd_reg[k][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    logic [15:0] avg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            avg[k] = (div_reg[k] == '0) ? 16'd0 : dvd_reg[k][15:0];
        end
    end

    // Luma: one product per cycle into the accumulator
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] prod;

    assign prod = ACC_W'(luma_coef(cmd.mul_sel) * avg[cmd.mul_sel]);

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_reg + prod;
        end
    end

    // Output register
    logic     ov_reg;
    bnd_out_t od_reg;

    assign sts.emit = emit;
    assign sts.mono_result = mono_res;
    assign sts.out_free = !ov_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            ov_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            od_reg.gray <= mono_item_reg ? v_reg : acc_reg[ACC_W-1:16];
            od_reg.red <= mono_item_reg ? 16'd0 : avg[CLR_RED];
            od_reg.green <= mono_item_reg ? 16'd0 : avg[CLR_GREEN];
            od_reg.blue <= mono_item_reg ? 16'd0 : avg[CLR_BLUE];
            od_reg.frame_last <= last_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

endmodule

/* design/bayer_neighbourhood_demosaic.sv */
// Top level of the Bayer 3x3 neighborhood demosaic.
// Depends on bnd_pkg, bnd_ctrl, bnd_dp (which holds two bnd_ram line banks).
//
//   channel | direction | handshake           | beat
//   in      | in        | in_valid / in_stall   | bnd_in_t  {func, raw_sample}
//   out     | out       | out_valid / out_stall | bnd_out_t {gray, red, green, blue, frame_last}
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// Steps: an item with no result passes capture and window step; a mono sample
// adds the output load; a demosaiced pixel passes capture, window step, sum, 20
// divider steps, 3 luma multiply steps and load.
// Reset clears counters and window and restores config defaults; the line store is not cleared.
// The output register holds a beat under out_stall while the next item is
// accepted; the sequencer waits in its load step only if that beat still sits.
module bayer_neighbourhood_demosaic #(
    parameter int MAX_WIDTH = bnd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bnd_pkg::bnd_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bnd_pkg::bnd_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [bnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bnd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bnd_pkg::*;

    bnd_cmd_t cmd;
    bnd_sts_t sts;

    // Sequencer: one item in flight, holds in_stall high until it retires
    bnd_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts(sts),
        .cmd(cmd)
    );

    // Datapath: line banks, window, arithmetic and the output register
    bnd_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .in_data(in_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .sts(sts),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

endmodule

/* design/bnd_checker.sv */
// Port-level checker for the demosaic, bound to the top level.
// Depends on bnd_pkg and bayer_neighbourhood_demosaic.
module bnd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input bnd_pkg::bnd_in_t                in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input bnd_pkg::bnd_out_t               out_data,
    input logic                            cfg_we,
    input logic [bnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bnd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bnd_pkg::*;

    // Held output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");

    // One item at a time: an accepted beat stalls the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // A new result appears only from a busy block
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in flight");

endmodule

bind bayer_neighbourhood_demosaic bnd_checker u_bnd_checker (.*);
